// File: hw/rtl/ile_pkg.sv
// Shared widths, request and status codes for the indexed list engine.
`default_nettype none

package ile_pkg;

  // Store geometry
  localparam int unsigned Capacity = 256;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 9;
  localparam int unsigned FposW    = 8;

  // Request codes
  typedef enum logic [2:0] {
    REQ_APPEND     = 3'd0,
    REQ_INSERT     = 3'd1,
    REQ_REMOVE_AT  = 3'd2,
    REQ_REMOVE_VAL = 3'd3,
    REQ_READ       = 3'd4,
    REQ_WRITE      = 3'd5,
    REQ_FIND       = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

endpackage

`default_nettype wire

// File: hw/rtl/ile_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module ile_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/indexed_list_engine.sv
// Top level of the indexed list engine: request sequencer around the entry RAM.
//
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries one item: req_type_i,
//   position_i, item_value_i. Result channel (out_valid_o/out_ready_i)
//   returns exactly one item per request: status, read value, found
//   position and flag, plus the entry count and empty flag after it.
//   Entries 0 .. count-1 live in a 256 x 32 RAM with one read port and
//   one write port; shifts stream one entry per cycle through that RAM.
// Request handling:
//   append, write, clear, insert at p = count and every refused request
//   finish without a scan. read fetches entry p; find scans from 0 and
//   stops on a hit; remove at p shifts entries p+1 .. count-1 down;
//   remove value scans the whole list, hit or miss; insert at p < count
//   walks down from the tail, moving each entry up, then fills slot p.
// One request is in flight at a time; a new item is taken once the result
// register is empty and the sequencer is idle.
// Reset clears the count (empty list); RAM contents are not cleared.
// A stalled receiver holds the result; no new item is taken meanwhile.
`default_nettype none

module indexed_list_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        req_type_i,
  input  logic [ile_pkg::PosW-1:0]          position_i,
  input  logic signed [ile_pkg::DataW-1:0]  item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [ile_pkg::DataW-1:0]  read_value_o,
  output logic [ile_pkg::FposW-1:0]         found_position_o,
  output logic                              found_o,
  output logic [ile_pkg::CntW-1:0]          entry_count_o,
  output logic                              is_empty_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [ile_pkg::CntW-1:0] CapCnt = ile_pkg::CntW'(ile_pkg::Capacity);

  // Control state
  logic [1:0]                     state_q, state_d;
  logic                           ov_q, ov_d;
  logic [ile_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                           iss_q, iss_d;
  logic                           pend_q, pend_d;
  logic                           plast_q, plast_d;
  // Request and result payload
  ile_pkg::req_e                  op_q, op_d;
  logic [ile_pkg::PosW-1:0]       pos_q, pos_d;
  logic [ile_pkg::DataW-1:0]      val_q, val_d;
  logic [ile_pkg::AddrW-1:0]      idx_q, idx_d;
  logic [ile_pkg::AddrW-1:0]      paddr_q, paddr_d;
  logic                           hit_q, hit_d;
  logic                           found_q, found_d;
  logic [ile_pkg::FposW-1:0]      where_q, where_d;
  logic [ile_pkg::DataW-1:0]      rdv_q, rdv_d;
  ile_pkg::status_e               st_q, st_d;

  // RAM port
  logic                           mem_we, mem_re;
  logic [ile_pkg::AddrW-1:0]      mem_waddr, mem_raddr;
  logic [ile_pkg::DataW-1:0]      mem_wdata, mem_rdata;

  logic accept, scan_up, last_up, last_dn, is_last, match;

  ile_ram #(
    .Depth(ile_pkg::Capacity),
    .Width(ile_pkg::DataW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE) && !ov_q;
  assign accept     = in_valid_i && in_ready_o;

  // Scan direction and end-of-walk detection
  assign scan_up = (op_q != ile_pkg::REQ_INSERT);
  assign last_up = ({1'b0, idx_q} == (cnt_q - ile_pkg::CntW'(1)));
  assign last_dn = (idx_q == pos_q[ile_pkg::AddrW-1:0]);
  assign is_last = scan_up ? last_up : last_dn;

  // Hit test: read data against the value for find and remove value, read address against the position otherwise
  always_comb begin
    if (op_q == ile_pkg::REQ_REMOVE_VAL || op_q == ile_pkg::REQ_FIND) begin
      match = (mem_rdata == val_q);
    end else begin
      match = (paddr_q == pos_q[ile_pkg::AddrW-1:0]);
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ov_d      = ov_q;
    cnt_d     = cnt_q;
    iss_d     = iss_q;
    pend_d    = 1'b0;
    plast_d   = 1'b0;
    op_d      = op_q;
    pos_d     = pos_q;
    val_d     = val_q;
    idx_d     = idx_q;
    paddr_d   = idx_q;
    hit_d     = hit_q;
    found_d   = found_q;
    where_d   = where_q;
    rdv_d     = rdv_q;
    st_d      = st_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = idx_q;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    // New request
    if (accept) begin
      op_d    = ile_pkg::req_e'(req_type_i);
      pos_d   = position_i;
      val_d   = item_value_i;
      hit_d   = 1'b0;
      found_d = 1'b0;
      where_d = '0;
      rdv_d   = '0;
      st_d    = ile_pkg::ST_OK;
      unique case (ile_pkg::req_e'(req_type_i))
        ile_pkg::REQ_APPEND: begin
          ov_d = 1'b1;
          if (cnt_q == CapCnt) begin
            st_d = ile_pkg::ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cnt_q[ile_pkg::AddrW-1:0];
            mem_wdata = item_value_i;
            cnt_d     = cnt_q + ile_pkg::CntW'(1);
          end
        end
        ile_pkg::REQ_INSERT: begin
          if (position_i > cnt_q) begin
            st_d = ile_pkg::ST_RANGE;
            ov_d = 1'b1;
          end else if (cnt_q == CapCnt) begin
            st_d = ile_pkg::ST_FULL;
            ov_d = 1'b1;
          end else if (position_i == cnt_q) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_q[ile_pkg::AddrW-1:0];
            mem_wdata = item_value_i;
            cnt_d     = cnt_q + ile_pkg::CntW'(1);
            ov_d      = 1'b1;
          end else begin
            // walk down from the tail, moving each entry up by one
            state_d = S_SCAN;
            iss_d   = 1'b1;
            idx_d   = ile_pkg::AddrW'(cnt_q - ile_pkg::CntW'(1));
          end
        end
        ile_pkg::REQ_REMOVE_AT, ile_pkg::REQ_READ: begin
          if (position_i >= cnt_q) begin
            st_d = ile_pkg::ST_RANGE;
            ov_d = 1'b1;
          end else begin
            state_d = S_SCAN;
            iss_d   = 1'b1;
            idx_d   = position_i[ile_pkg::AddrW-1:0];
          end
        end
        ile_pkg::REQ_REMOVE_VAL, ile_pkg::REQ_FIND: begin
          if (cnt_q == '0) begin
            st_d = ile_pkg::ST_NOTFOUND;
            ov_d = 1'b1;
          end else begin
            state_d = S_SCAN;
            iss_d   = 1'b1;
            idx_d   = '0;
          end
        end
        ile_pkg::REQ_WRITE: begin
          ov_d = 1'b1;
          if (position_i >= cnt_q) begin
            st_d = ile_pkg::ST_RANGE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = position_i[ile_pkg::AddrW-1:0];
            mem_wdata = item_value_i;
          end
        end
        ile_pkg::REQ_CLEAR: begin
          cnt_d = '0;
          ov_d  = 1'b1;
        end
        default: begin
          ov_d = 1'b1;
        end
      endcase
    end

    // Read issue: one entry per cycle
    if (state_q == S_SCAN && iss_q) begin
      mem_re  = 1'b1;
      pend_d  = 1'b1;
      plast_d = is_last;
      paddr_d = idx_q;
      idx_d   = scan_up ? idx_q + ile_pkg::AddrW'(1) : idx_q - ile_pkg::AddrW'(1);
      if (is_last) begin
        iss_d = 1'b0;
      end
    end

    // Returning read data: compare and/or move the entry
    if (state_q == S_SCAN && pend_q) begin
      if (!scan_up) begin
        mem_we    = 1'b1;
        mem_waddr = paddr_q + ile_pkg::AddrW'(1);
        mem_wdata = mem_rdata;
        if (plast_q) begin
          state_d = S_FIN;
        end
      end else begin
        if (hit_q) begin
          mem_we    = 1'b1;
          mem_waddr = paddr_q - ile_pkg::AddrW'(1);
          mem_wdata = mem_rdata;
        end else if (match) begin
          hit_d = 1'b1;
          if (op_q != ile_pkg::REQ_FIND) begin
            rdv_d = mem_rdata;
          end
          if (op_q == ile_pkg::REQ_FIND || op_q == ile_pkg::REQ_REMOVE_VAL) begin
            found_d = 1'b1;
            where_d = ile_pkg::FposW'(paddr_q);
          end
        end

        if (!hit_q && match &&
            (op_q == ile_pkg::REQ_FIND || op_q == ile_pkg::REQ_READ)) begin
          state_d = S_IDLE;
          ov_d    = 1'b1;
          iss_d   = 1'b0;
          pend_d  = 1'b0;
        end else if (plast_q) begin
          state_d = S_IDLE;
          ov_d    = 1'b1;
          iss_d   = 1'b0;
          pend_d  = 1'b0;
          if (hit_q || match) begin
            cnt_d = cnt_q - ile_pkg::CntW'(1);
          end else begin
            st_d = ile_pkg::ST_NOTFOUND;
          end
        end
      end
    end

    // Insert tail: drop the new value into the opened slot
    if (state_q == S_FIN) begin
      mem_we    = 1'b1;
      mem_waddr = pos_q[ile_pkg::AddrW-1:0];
      mem_wdata = val_q;
      cnt_d     = cnt_q + ile_pkg::CntW'(1);
      state_d   = S_IDLE;
      ov_d      = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      iss_q   <= 1'b0;
      pend_q  <= 1'b0;
      plast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      plast_q <= plast_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    idx_q   <= idx_d;
    paddr_q <= paddr_d;
    hit_q   <= hit_d;
    found_q <= found_d;
    where_q <= where_d;
    rdv_q   <= rdv_d;
    st_q    <= st_d;
  end

  // Result port
  assign out_valid_o      = ov_q;
  assign status_o         = st_q;
  assign read_value_o     = rdv_q;
  assign found_position_o = where_q;
  assign found_o          = found_q;
  assign entry_count_o    = cnt_q;
  assign is_empty_o       = (cnt_q == '0);

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCnt)
    else $error("entry count above capacity");

  a_wr_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_waddr} <= cnt_q))
    else $error("RAM write beyond list tail");

  a_cnt_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> ov_q)
    else $error("count changed without a result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> (state_q == S_IDLE && !iss_q))
    else $error("result raised while sequencer busy");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && found_q) |-> (st_q == ile_pkg::ST_OK))
    else $error("found flag with non-ok status");

endmodule

`default_nettype wire
